// ===== rtl/core/crt_pkg.sv =====
package crt_pkg;

    localparam int MOD_BITS = 16;
    localparam int ACC_BITS = 64;

    // Dividend of the remainder unit: t + offset can carry one bit past ACC_BITS.
    localparam int DIV_W   = ACC_BITS + 1;
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    // Full product of step and modulus.
    localparam int PROD_W  = ACC_BITS + MOD_BITS;
    localparam int MCNT_W  = $clog2(MOD_BITS + 1);

    localparam int SOL_W   = 63;
    localparam int IN_W    = 16;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOSOL = 2'd1,
        ST_OVF   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START_T,
        S_WAIT_T,
        S_START_S,
        S_WAIT_S,
        S_SIEVE,
        S_WAIT_MUL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/core/crt_rem_unit.sv =====
module crt_rem_unit
    import crt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_W-1:0]    dividend,
    input  logic [MOD_BITS-1:0] divisor,
    output unit_stat_t          stat,
    output logic [MOD_BITS-1:0] rem
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]    dvd_reg, dvd_next;
    logic [MOD_BITS-1:0] rem_reg, rem_next;
    logic [MOD_BITS-1:0] dvs_reg, dvs_next;

    logic [MOD_BITS:0]   shifted;
    logic [MOD_BITS:0]   diff;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DIV_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            rem_next = (shifted >= {1'b0, dvs_reg}) ? diff[MOD_BITS-1:0]
                                                    : shifted[MOD_BITS-1:0];
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

endmodule

// ===== rtl/core/crt_mul_unit.sv =====
module crt_mul_unit
    import crt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ACC_BITS-1:0] mcand,
    input  logic [MOD_BITS-1:0] mplier,
    output unit_stat_t          stat,
    output logic [PROD_W-1:0]   product
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [MCNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]   mcand_reg, mcand_next;
    logic [MOD_BITS-1:0] mplier_reg, mplier_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;

    // Shift-and-add, one multiplier bit per cycle, LSB first.
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = MCNT_W'(MOD_BITS);
            mcand_next  = PROD_W'(mcand);
            mplier_next = mplier;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MOD_BITS-1:1]};
            cnt_next    = cnt_reg - MCNT_W'(1);
            if (cnt_reg == MCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

// ===== rtl/core/crt_sieve_solver.sv =====
// Per item: the bit-serial remainder unit runs twice (t + offset, then step), then the
//   sieve makes one try per cycle, k tries in all (k = sieve tries, at most modulus).
// Throughput: one item at a time; an item with an error already pending skips the arithmetic.
// The result waits in an output register, so the next item is taken while it is pending.
// Reset (rst_n, asynchronous, active low): t = 0, step = 1, status ok, no result pending.
module crt_sieve_solver
    import crt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] modulus, [31:16] offset
    input  logic        s_tlast,   // is_last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [62:0] solution, [63] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    // ------------------------------------------------------------------
    // Problem state
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [ACC_BITS-1:0] t_reg, t_next;
    logic [ACC_BITS-1:0] step_reg, step_next;
    status_t             err_reg, err_next;

    // Per-item working registers
    logic [MOD_BITS-1:0] m_reg, m_next;
    logic [MOD_BITS-1:0] off_reg, off_next;
    logic                last_reg, last_next;
    logic [MOD_BITS-1:0] r_reg, r_next;
    logic [MOD_BITS-1:0] s_reg, s_next;
    logic [MOD_BITS-1:0] k_reg, k_next;
    logic [ACC_BITS-1:0] tcand_reg, tcand_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [SOL_W-1:0]    out_sol_reg, out_sol_next;
    status_t             out_st_reg, out_st_next;

    // Arithmetic units; the remainder unit is shared by both reductions
    logic                rem_start;
    logic [DIV_W-1:0]    rem_dividend;
    unit_stat_t          rem_stat;
    logic [MOD_BITS-1:0] rem_value;
    logic                mul_start;
    unit_stat_t          mul_stat;
    logic [PROD_W-1:0]   mul_product;

    // Input field decode; keep the low MOD_BITS bits of each field.
    logic [31:0]         mod_wide;
    logic [31:0]         off_wide;
    logic [MOD_BITS-1:0] in_mod;
    logic [MOD_BITS-1:0] in_off;
    logic                in_fire;

    // Sieve arithmetic
    logic [MOD_BITS:0]   r_sum;
    logic [MOD_BITS:0]   r_wrap;
    logic                step_ovf;
    logic [63:0]         t_wide;

    assign mod_wide = {{(32-IN_W){1'b0}}, s_tdata[IN_W-1:0]};
    assign off_wide = {{(32-IN_W){1'b0}}, s_tdata[2*IN_W-1:IN_W]};
    assign in_mod   = mod_wide[MOD_BITS-1:0];
    assign in_off   = off_wide[MOD_BITS-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // Reduce t + offset first, then step; both go through the one remainder unit.
    assign rem_dividend = (state_reg == S_START_S) ? DIV_W'(step_reg)
                                                   : DIV_W'(t_reg) + DIV_W'(off_reg);

    crt_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (m_reg),
        .stat     (rem_stat),
        .rem      (rem_value)
    );

    // Step times modulus runs alongside the reductions; its high bits flag overflow.
    crt_mul_unit u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (step_reg),
        .mplier  (m_reg),
        .stat    (mul_stat),
        .product (mul_product)
    );

    // Next residue of t + offset after one more whole step.
    assign r_sum    = {1'b0, r_reg} + {1'b0, s_reg};
    assign r_wrap   = r_sum - {1'b0, m_reg};
    assign step_ovf = |mul_product[PROD_W-1:ACC_BITS-1];
    assign t_wide   = 64'(t_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        step_next      = step_reg;
        err_next       = err_reg;
        m_next         = m_reg;
        off_next       = off_reg;
        last_next      = last_reg;
        r_next         = r_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        tcand_next     = tcand_reg;
        out_valid_next = out_valid_reg;
        out_sol_next   = out_sol_reg;
        out_st_next    = out_st_reg;
        rem_start      = 1'b0;
        mul_start      = 1'b0;

        // Drop the pending result once taken.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    m_next    = in_mod;
                    off_next  = in_off;
                    last_next = s_tlast;
                    if (err_reg != ST_OK)
                    begin
                        // Sticky error: skip the work, just wait for the last item.
                        state_next = S_FINISH;
                    end
                    else if (in_mod == '0)
                    begin
                        err_next   = ST_NOSOL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_START_T;
                    end
                end
            end

            S_START_T:
            begin
                rem_start  = 1'b1;
                mul_start  = 1'b1;
                state_next = S_WAIT_T;
            end

            S_WAIT_T:
            begin
                if (rem_stat.done)
                begin
                    r_next     = rem_value;
                    state_next = S_START_S;
                end
            end

            S_START_S:
            begin
                rem_start  = 1'b1;
                state_next = S_WAIT_S;
            end

            S_WAIT_S:
            begin
                if (rem_stat.done)
                begin
                    s_next     = rem_value;
                    k_next     = '0;
                    tcand_next = t_reg;
                    state_next = S_SIEVE;
                end
            end

            S_SIEVE:
            begin
                // One candidate per cycle: test the residue, give up after the last try, else advance t by one step.
                if (r_reg == '0)
                begin
                    state_next = S_WAIT_MUL;
                end
                else if (k_reg == m_reg - MOD_BITS'(1))
                begin
                    err_next   = ST_NOSOL;
                    state_next = S_FINISH;
                end
                else
                begin
                    r_next     = (r_sum >= {1'b0, m_reg}) ? r_wrap[MOD_BITS-1:0]
                                                          : r_sum[MOD_BITS-1:0];
                    tcand_next = tcand_reg + step_reg;
                    k_next     = k_reg + MOD_BITS'(1);
                end
            end

            S_WAIT_MUL:
            begin
                if (!mul_stat.busy)
                begin
                    if (step_ovf)
                    begin
                        err_next = ST_OVF;
                    end
                    else
                    begin
                        t_next    = tcand_reg;
                        step_next = mul_product[ACC_BITS-1:0];
                    end
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    // Load the result and start a fresh problem.
                    out_valid_next = 1'b1;
                    out_sol_next   = (err_reg == ST_OK) ? t_wide[SOL_W-1:0] : '0;
                    out_st_next    = err_reg;
                    t_next         = '0;
                    step_next      = ACC_BITS'(1);
                    err_next       = ST_OK;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= '0;
            step_reg      <= ACC_BITS'(1);
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            step_reg      <= step_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg       <= m_next;
        off_reg     <= off_next;
        last_reg    <= last_next;
        r_reg       <= r_next;
        s_reg       <= s_next;
        k_reg       <= k_next;
        tcand_reg   <= tcand_next;
        out_sol_reg <= out_sol_next;
        out_st_reg  <= out_st_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_sol_reg};
    assign m_tuser  = out_st_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!rem_stat.busy && !mul_stat.busy))
        else $error("arithmetic unit still busy while taking a new item");

    a_sieve_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIEVE) |-> ((r_reg < m_reg) && (s_reg < m_reg) && (k_reg < m_reg)))
        else $error("sieve residue or try count out of range");

    a_error_zero_solution: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
        else $error("error result carries a nonzero solution");

    a_t_below_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (t_reg < step_reg))
        else $error("running solution not below step");

endmodule
